// ===== hw/rtl/apsp_pkg.sv =====
// ---------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants for the all-pairs shortest path block.
// ---------------------------------------------------------------------------
package apsp_pkg;

  // Command codes carried in the request.
  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdCompute = 2'd1;
  localparam logic [1:0] CmdRead    = 2'd2;
  localparam logic [1:0] CmdUnused  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] CfgVertexCount  = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgInfinityCode = 1'd1;

  localparam int unsigned VertexCountBits = 5;
  localparam int unsigned InfinityBits    = 16;
  localparam int unsigned CfgDataBits     = 16;

  localparam logic [VertexCountBits-1:0] VertexCountReset = 5'd16;
  localparam logic [InfinityBits-1:0]    InfinityReset    = 16'd999;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;
  } apsp_req_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        no_path;
    logic        done_res;
  } apsp_res_t;

  // Decisions of the shared relaxation unit.
  typedef struct packed {
    logic left_inf;
    logic update;
  } apsp_relax_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_LEFT_RD,
    ST_LEFT_CHK,
    ST_PAIR_RD,
    ST_PAIR_UPD,
    ST_FINISH
  } apsp_state_e;

endpackage

// ===== hw/rtl/apsp_mem.sv =====
// ---------------------------------------------------------------------------
// apsp_mem
// Distance matrix storage: one write port and two registered read ports.
// ---------------------------------------------------------------------------
module apsp_mem #(
  parameter int unsigned AddrBits = 8,
  parameter int unsigned DataBits = 16
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] raddr_a_i,
  input  logic [AddrBits-1:0] raddr_b_i,
  output logic [DataBits-1:0] rdata_a_o,
  output logic [DataBits-1:0] rdata_b_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [DataBits-1:0] mem_q [Depth];
  logic [DataBits-1:0] rdata_a_q;
  logic [DataBits-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/apsp_relax.sv =====
// ---------------------------------------------------------------------------
// apsp_relax
// Shared add and compare unit: decides whether a path through the
// intermediate vertex is shorter than the stored distance.
// ---------------------------------------------------------------------------
module apsp_relax #(
  parameter int unsigned WeightBits = 16
) (
  input  logic [WeightBits-1:0]            left_i,
  input  logic [WeightBits-1:0]            right_i,
  input  logic [WeightBits-1:0]            cell_i,
  input  logic [apsp_pkg::InfinityBits-1:0] inf_i,
  output logic [WeightBits-1:0]            sum_o,
  output apsp_pkg::apsp_relax_flags_t      flags_o
);
  import apsp_pkg::*;

  localparam int unsigned CmpBits = (WeightBits > InfinityBits) ? WeightBits : InfinityBits;

  logic [CmpBits-1:0]    inf_ext;
  logic                  right_inf;
  logic [WeightBits:0]   sum;

  assign inf_ext   = CmpBits'(inf_i);
  assign right_inf = (CmpBits'(right_i) == inf_ext);
  assign sum       = {1'b0, left_i} + {1'b0, right_i};

  assign flags_o.left_inf = (CmpBits'(left_i) == inf_ext);
  // A kept sum is below a stored value, so it always fits the weight width.
  assign flags_o.update   = !flags_o.left_inf && !right_inf && (sum < {1'b0, cell_i});
  assign sum_o            = sum[WeightBits-1:0];

endmodule

// ===== hw/rtl/all_pairs_shortest_path.sv =====
// ---------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall distance matrix with write, compute and read commands.
// ---------------------------------------------------------------------------
// Requests enter on in_valid_i / in_stall_o and results leave on
// out_valid_o / out_stall_i; a transfer happens when valid is high and stall
// is low. Configuration (vertex count, infinity code) is written on the
// cfg_* channel while the block is idle.
// A write request gives no result. A read request passes through the
// registered memory read, then loads the result.
// A compute request walks every (via, row) pair: it fetches and tests the
// row-to-via leg, then for each column reads both legs, then adds,
// compares and writes back; a row whose row-to-via leg is infinite is
// skipped. One add and compare unit and the matrix memory ports serve
// every step of the walk. in_stall_o is high for the
// whole of a read or compute request.
// The output register holds a result while out_stall_i is high; the
// sequencer waits in its last state until the register is free.
// Reset sets the vertex count to 16 and the infinity code to 999; the
// matrix contents are undefined until written.
// ---------------------------------------------------------------------------
module all_pairs_shortest_path #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  apsp_pkg::apsp_req_t                in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output apsp_pkg::apsp_res_t                out_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [apsp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [apsp_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import apsp_pkg::*;

  localparam int unsigned IdxBits  = $clog2(MAX_VERTICES);
  localparam int unsigned CntBits  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NumBits  = (CntBits > VertexCountBits) ? CntBits : VertexCountBits;
  localparam int unsigned ExtBits  = (CntBits > 4) ? CntBits : 4;
  localparam int unsigned AddrBits = 2 * IdxBits;
  localparam int unsigned CmpBits  = (WEIGHT_BITS > InfinityBits) ? WEIGHT_BITS : InfinityBits;

  apsp_state_e state_q, state_d;

  logic [VertexCountBits-1:0] vertex_count_q;
  logic [InfinityBits-1:0]    inf_q;

  logic [IdxBits-1:0]     via_q, via_d;
  logic [IdxBits-1:0]     row_q, row_d;
  logic [IdxBits-1:0]     col_q, col_d;
  logic [WEIGHT_BITS-1:0] left_q, left_d;
  logic                   read_ok_q, read_ok_d;
  logic                   out_valid_q, out_valid_d;
  apsp_res_t              out_res_q, out_res_d;

  logic [NumBits-1:0] num_full;
  logic [CntBits-1:0] num_act;
  logic [CntBits-1:0] num_last;
  logic               via_last, row_last, col_last;

  logic               in_acc;
  logic               out_free;
  logic [ExtBits-1:0] req_row, req_col;
  logic               req_in_store, req_in_use;

  logic                   mem_we;
  logic [AddrBits-1:0]    mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic                   mem_rd_en;
  logic [AddrBits-1:0]    mem_raddr_a, mem_raddr_b;
  logic [WEIGHT_BITS-1:0] mem_rdata_a, mem_rdata_b;

  logic [WEIGHT_BITS-1:0] relax_left;
  logic [WEIGHT_BITS-1:0] relax_sum;
  apsp_relax_flags_t      relax_flags;

  logic [CmpBits-1:0] read_dist;

  // Vertex counts above the matrix size saturate.
  assign num_full = (NumBits'(vertex_count_q) > NumBits'(MAX_VERTICES)) ?
                    NumBits'(MAX_VERTICES) : NumBits'(vertex_count_q);
  assign num_act  = num_full[CntBits-1:0];
  assign num_last = num_act - CntBits'(1);
  assign via_last = (CntBits'(via_q) == num_last);
  assign row_last = (CntBits'(row_q) == num_last);
  assign col_last = (CntBits'(col_q) == num_last);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == ST_IDLE);

  assign req_row      = ExtBits'(in_req_i.row);
  assign req_col      = ExtBits'(in_req_i.col);
  assign req_in_store = (req_row < ExtBits'(MAX_VERTICES)) && (req_col < ExtBits'(MAX_VERTICES));
  assign req_in_use   = (req_row < ExtBits'(num_act)) && (req_col < ExtBits'(num_act));

  assign read_dist = read_ok_q ? CmpBits'(mem_rdata_a) : CmpBits'(inf_q);

  assign relax_left = (state_q == ST_LEFT_CHK) ? mem_rdata_a : left_q;

  apsp_mem #(
    .AddrBits (AddrBits),
    .DataBits (WEIGHT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .rd_en_i   (mem_rd_en),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  apsp_relax #(
    .WeightBits (WEIGHT_BITS)
  ) u_relax (
    .left_i  (relax_left),
    .right_i (mem_rdata_a),
    .cell_i  (mem_rdata_b),
    .inf_i   (inf_q),
    .sum_o   (relax_sum),
    .flags_o (relax_flags)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.cmd)
            CmdCompute: state_d = (num_act == '0) ? ST_FINISH : ST_LEFT_RD;
            CmdRead:    state_d = ST_READ_WAIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ_WAIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_LEFT_RD: state_d = ST_LEFT_CHK;
      ST_LEFT_CHK: begin
        if (!relax_flags.left_inf) begin
          state_d = ST_PAIR_RD;
        end else if (row_last && via_last) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LEFT_RD;
        end
      end
      ST_PAIR_RD: state_d = ST_PAIR_UPD;
      ST_PAIR_UPD: begin
        if (!col_last) begin
          state_d = ST_PAIR_RD;
        end else if (row_last && via_last) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LEFT_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and counters.
  always_comb begin
    via_d       = via_q;
    row_d       = row_q;
    col_d       = col_q;
    left_d      = left_q;
    read_ok_d   = read_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    mem_we      = 1'b0;
    mem_waddr   = {row_q, col_q};
    mem_wdata   = relax_sum;
    mem_rd_en   = 1'b0;
    mem_raddr_a = {row_q, via_q};
    mem_raddr_b = {row_q, col_q};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.cmd)
            CmdWrite: begin
              mem_we    = req_in_store;
              mem_waddr = {req_row[IdxBits-1:0], req_col[IdxBits-1:0]};
              mem_wdata = WEIGHT_BITS'(in_req_i.weight);
            end
            CmdCompute: begin
              via_d = '0;
              row_d = '0;
              col_d = '0;
            end
            CmdRead: begin
              mem_rd_en   = 1'b1;
              mem_raddr_a = {req_row[IdxBits-1:0], req_col[IdxBits-1:0]};
              read_ok_d   = req_in_use;
            end
            default: ;
          endcase
        end
      end
      ST_READ_WAIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_res_d.distance = read_dist[15:0];
          out_res_d.no_path  = (read_dist == CmpBits'(inf_q));
          out_res_d.done_res = 1'b0;
        end
      end
      ST_LEFT_RD: begin
        mem_rd_en   = 1'b1;
        mem_raddr_a = {row_q, via_q};
      end
      ST_LEFT_CHK: begin
        left_d = mem_rdata_a;
        col_d  = '0;
        // A row whose leg to the via vertex is infinite has nothing to relax.
        if (relax_flags.left_inf) begin
          if (row_last) begin
            row_d = '0;
            via_d = via_last ? '0 : via_q + IdxBits'(1);
          end else begin
            row_d = row_q + IdxBits'(1);
          end
        end
      end
      ST_PAIR_RD: begin
        mem_rd_en   = 1'b1;
        mem_raddr_a = {via_q, col_q};
        mem_raddr_b = {row_q, col_q};
      end
      ST_PAIR_UPD: begin
        mem_we    = relax_flags.update;
        mem_waddr = {row_q, col_q};
        mem_wdata = relax_sum;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            row_d = '0;
            via_d = via_last ? '0 : via_q + IdxBits'(1);
          end else begin
            row_d = row_q + IdxBits'(1);
          end
        end else begin
          col_d = col_q + IdxBits'(1);
        end
      end
      ST_FINISH: begin
        via_d = '0;
        row_d = '0;
        col_d = '0;
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_res_d.distance = '0;
          out_res_d.no_path  = 1'b0;
          out_res_d.done_res = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      via_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      read_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      via_q       <= via_d;
      row_q       <= row_d;
      col_q       <= col_d;
      read_ok_q   <= read_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q    <= left_d;
    out_res_q <= out_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VertexCountReset;
      inf_q          <= InfinityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgVertexCount:  vertex_count_q <= cfg_data_i[VertexCountBits-1:0];
        CfgInfinityCode: inf_q          <= cfg_data_i[InfinityBits-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== test/apsp_distance_checker.sv =====
// ---------------------------------------------------------------------------
// apsp_distance_checker
// Watches the request, result and configuration channels of the
// all-pairs shortest path block. It keeps its own copy of the distance
// matrix and the two registers, works out the answer to every accepted
// compute and read request and compares each accepted result with the oldest answer due.
// ---------------------------------------------------------------------------
module apsp_distance_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  apsp_pkg::apsp_req_t               in_req_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  apsp_pkg::apsp_res_t               out_res_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [apsp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [apsp_pkg::CfgDataBits-1:0] cfg_data_i,
  output int unsigned                       pending_o,
  output int unsigned                       fail_count_o,
  output int unsigned                       checked_o
);
  import apsp_pkg::*;

  localparam int unsigned MaxVertices = 16;

  logic [15:0] dist_mat [MaxVertices][MaxVertices];
  logic [VertexCountBits-1:0] vertex_count;
  logic [InfinityBits-1:0] inf_code;
  apsp_res_t answers_due [$];
  apsp_res_t want;
  logic [15:0] read_dist;
  int unsigned fails = 0;
  int unsigned checked = 0;

  function automatic int unsigned live_vertices();
    return (vertex_count > MaxVertices) ? MaxVertices : int'(vertex_count);
  endfunction

  // In-place relaxation over every intermediate vertex. The row-to-via leg
  // is fetched once per row, the via-to-column leg freshly per column.
  function automatic void relax_matrix();
    int unsigned n;
    logic [15:0] left_leg;
    logic [15:0] right_leg;
    logic [16:0] leg_sum;
    n = live_vertices();
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        left_leg = dist_mat[i][k];
        if (left_leg == inf_code) continue;
        for (int j = 0; j < n; j++) begin
          right_leg = dist_mat[k][j];
          leg_sum = {1'b0, left_leg} + {1'b0, right_leg};
          if (right_leg != inf_code && leg_sum < {1'b0, dist_mat[i][j]}) begin
            dist_mat[i][j] = leg_sum[15:0];
          end
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      vertex_count = VertexCountReset;
      inf_code = InfinityReset;
      answers_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgVertexCount:  vertex_count = cfg_data_i[VertexCountBits-1:0];
          CfgInfinityCode: inf_code = cfg_data_i[InfinityBits-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $error("result with nothing due: distance %0d no_path %0d done_res %0d",
                 out_res_i.distance, out_res_i.no_path, out_res_i.done_res);
          fails++;
        end else begin
          want = answers_due.pop_front();
          checked++;
          if (out_res_i.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_res_i.distance);
            fails++;
          end
          if (out_res_i.no_path !== want.no_path) begin
            $error("no_path: expected %0d, got %0d", want.no_path, out_res_i.no_path);
            fails++;
          end
          if (out_res_i.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_res_i.done_res);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_req_i.cmd)
          CmdWrite: dist_mat[in_req_i.row][in_req_i.col] = in_req_i.weight;
          CmdCompute: begin
            relax_matrix();
            want.distance = '0;
            want.no_path = 1'b0;
            want.done_res = 1'b1;
            answers_due.push_back(want);
          end
          CmdRead: begin
            // Anything outside the vertices in use reads as no path.
            if (in_req_i.row < live_vertices() && in_req_i.col < live_vertices()) begin
              read_dist = dist_mat[in_req_i.row][in_req_i.col];
            end else begin
              read_dist = inf_code;
            end
            want.distance = read_dist;
            want.no_path = (read_dist == inf_code);
            want.done_res = 1'b0;
            answers_due.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending_o <= answers_due.size();
    fail_count_o <= fails;
    checked_o <= checked;
  end

endmodule

// ===== test/tb_all_pairs_shortest_path.sv =====
// ---------------------------------------------------------------------------
// tb_all_pairs_shortest_path
// Stimulus and verdict for the all-pairs shortest path block. The matrix is
// filled once, a directed set of requests covers the field extremes and the
// corner cases, then randomized phases of writes, computes and reads run
// under a range of vertex counts and infinity codes, with random idling on
// both channels. The checker beside the block does the prediction.
// ---------------------------------------------------------------------------
module tb_all_pairs_shortest_path;
  import apsp_pkg::*;

  localparam int unsigned MaxVertices   = 16;
  localparam int unsigned PhaseCount    = 24;
  localparam int unsigned PhaseItems    = 36;
  localparam int unsigned SettleCycles  = 8;
  // The limit must outlast a compute over 16 vertices, during which no request or setting is taken.
  localparam int unsigned WatchdogLimit = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  apsp_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  apsp_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned checked;

  bit calm = 1'b0;
  logic [VertexCountBits-1:0] cur_vc = VertexCountReset;
  logic [InfinityBits-1:0] cur_inf = InfinityReset;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  int unsigned quiet_cycles = 0;
  int unsigned n_writes = 0;
  int unsigned n_computes = 0;
  int unsigned n_reads = 0;
  int unsigned n_ignored = 0;
  int unsigned n_settings = 0;

  all_pairs_shortest_path dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  apsp_distance_checker u_dist_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_res_i    (out_res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int unsigned live_vertices();
    return (cur_vc > MaxVertices) ? MaxVertices : int'(cur_vc);
  endfunction

  function automatic logic [3:0] pick_vertex();
    if (live_vertices() == 0) return 4'($urandom_range(0, MaxVertices - 1));
    return 4'($urandom_range(0, live_vertices() - 1));
  endfunction

  // Mostly short edges, with missing edges and full-range values mixed in.
  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0, 1:    return cur_inf;
      2:       return 16'($urandom);
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 60));
    endcase
  endfunction

  // The receiver draws a fresh stall length after every accepted result.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_draw = pick_gap();
      stall_left <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("** all_pairs_shortest_path: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [3:0] row, input logic [3:0] col,
                          input logic [15:0] weight);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= {cmd, row, col, weight};
    do @(posedge clk); while (in_stall !== 1'b0);
    case (cmd)
      CmdWrite:   n_writes++;
      CmdCompute: n_computes++;
      CmdRead:    n_reads++;
      default:    n_ignored++;
    endcase
  endtask

  // Returns once every answer due has arrived and the last write has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [VertexCountBits-1:0] vc,
                               input logic [InfinityBits-1:0] inf);
    logic [CfgDataBits-1:0] vc_word;
    wait_idle();
    // Bits above the register width are junk and must be dropped.
    vc_word = {11'($urandom), vc};
    cfg_valid <= 1'b1;
    cfg_index <= CfgVertexCount;
    cfg_data <= vc_word;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CfgInfinityCode;
    cfg_data <= inf;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_vc = vc;
    cur_inf = inf;
    n_settings++;
  endtask

  function automatic logic [VertexCountBits-1:0] phase_vertices(input int unsigned p);
    return (p == 0) ? 5'd1 : (p == 5) ? 5'd16 : (p == 11) ? 5'd17 : (p == 17) ? 5'd31 :
           (p == 23) ? 5'd12 : (p % 8 == 6) ? 5'd0 : 5'($urandom_range(2, 8));
  endfunction

  function automatic logic [InfinityBits-1:0] phase_infinity(input int unsigned p);
    case (p % 5)
      0:       return InfinityReset;
      1:       return 16'($urandom_range(1, 65534));
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(20, 120));
    endcase
  endfunction

  // Edges are mostly written inside the vertices in use, then relaxed and
  // read back; stray reads and the unused command are mixed in as noise.
  task automatic run_phase(input int unsigned items);
    int unsigned kind;
    int unsigned computes;
    int unsigned max_computes;
    computes = 0;
    max_computes = (live_vertices() > 8) ? 1 : 4;
    for (int i = 0; i < items; i++) begin
      kind = $urandom_range(0, 99);
      if ((kind < 6 && computes < max_computes) || (i == items / 2 && computes == 0)) begin
        send_req(CmdCompute, 4'($urandom), 4'($urandom), 16'($urandom));
        computes++;
      end else if (kind < 42) begin
        send_req(CmdWrite, pick_vertex(), pick_vertex(), rand_weight());
      end else if (kind < 45) begin
        send_req(CmdWrite, 4'($urandom), 4'($urandom), rand_weight());
      end else if (kind < 90) begin
        send_req(CmdRead, pick_vertex(), pick_vertex(), 16'($urandom));
      end else if (kind < 97) begin
        send_req(CmdRead, 4'($urandom), 4'($urandom), 16'($urandom));
      end else begin
        send_req(CmdUnused, 4'($urandom), 4'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_setting(VertexCountReset, InfinityReset);

    // Every entry is written once, so no read or compute touches an
    // unwritten one.
    for (int r = 0; r < MaxVertices; r++) begin
      for (int c = 0; c < MaxVertices; c++) begin
        send_req(CmdWrite, 4'(r), 4'(c), rand_weight());
      end
    end

    send_req(CmdRead, 4'd0, 4'd0, 16'h0000);
    send_req(CmdRead, 4'd15, 4'd15, 16'hFFFF);
    send_req(CmdRead, 4'd0, 4'd15, 16'h0000);
    send_req(CmdRead, 4'd15, 4'd0, 16'hFFFF);
    send_req(CmdWrite, 4'd3, 4'd4, 16'hFFFF);
    send_req(CmdRead, 4'd3, 4'd4, 16'h0000);
    send_req(CmdWrite, 4'd3, 4'd5, 16'h0000);
    send_req(CmdRead, 4'd3, 4'd5, 16'h0000);
    send_req(CmdWrite, 4'd3, 4'd6, InfinityReset);
    send_req(CmdRead, 4'd3, 4'd6, 16'h0000);
    send_req(CmdUnused, 4'd15, 4'd15, 16'hFFFF);
    send_req(CmdCompute, 4'd0, 4'd0, 16'h0000);
    send_req(CmdRead, 4'd3, 4'd4, 16'h0000);

    // Reads beyond the vertices in use answer no path.
    apply_setting(5'd4, InfinityReset);
    send_req(CmdRead, 4'd4, 4'd0, 16'h0000);
    send_req(CmdRead, 4'd0, 4'd15, 16'h0000);
    send_req(CmdRead, 4'd15, 4'd15, 16'h0000);
    send_req(CmdRead, 4'd3, 4'd3, 16'h0000);

    // With no vertices a compute changes nothing and every read misses.
    apply_setting(5'd0, InfinityReset);
    send_req(CmdCompute, 4'd0, 4'd0, 16'h0000);
    send_req(CmdRead, 4'd0, 4'd0, 16'h0000);

    // A count above the maximum saturates.
    apply_setting(5'd31, 16'hFFFF);
    send_req(CmdRead, 4'd15, 4'd15, 16'h0000);
    send_req(CmdRead, 4'd0, 4'd0, 16'h0000);

    for (int p = 0; p < PhaseCount; p++) begin
      apply_setting(phase_vertices(p), phase_infinity(p));
      calm = ($urandom_range(0, 3) == 0);
      run_phase(PhaseItems);
    end
    calm = 1'b0;
    wait_idle();

    $display("Sent %0d writes, %0d computes, %0d reads and %0d unused commands",
             n_writes, n_computes, n_reads, n_ignored);
    $display("under %0d register settings; %0d results compared.", n_settings, checked);
    if (fail_count == 0) begin
      $display("** all_pairs_shortest_path: PASSED **");
    end else begin
      $display("** all_pairs_shortest_path: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/apsp_pkg.sv
hw/rtl/apsp_mem.sv
hw/rtl/apsp_relax.sv
hw/rtl/all_pairs_shortest_path.sv
test/apsp_distance_checker.sv
test/tb_all_pairs_shortest_path.sv
